@@ hw/rtl/stsi_pkg.sv @@
// Shared constants, status codes and interface types for the sorted key table.
package stsi_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int CW          = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int ST_W        = 3;
	localparam int POS_W       = 6;
	localparam int ENT_W       = 7;

	localparam logic [ST_W-1:0] ST_APPENDED = 3'd0;
	localparam logic [ST_W-1:0] ST_SWAPPED  = 3'd1;
	localparam logic [ST_W-1:0] ST_AT_LAST  = 3'd2;
	localparam logic [ST_W-1:0] ST_INSERTED = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef struct packed {
		logic                    we;
		logic [AW-1:0]           waddr;
		logic signed [KEY_W-1:0] wdata;
		logic                    re;
		logic [AW-1:0]           raddr;
	} mem_req_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

	typedef struct packed {
		logic            done;
		logic [ST_W-1:0] status;
		logic [AW-1:0]   pos;
		logic [CW-1:0]   fill;
	} res_t;

endpackage

@@ hw/rtl/stsi_ram.sv @@
// Key table storage: one write port, one read port with registered data.
module stsi_ram (
	input  logic                             clk,
	input  stsi_pkg::mem_req_t               req,
	output logic signed [stsi_pkg::KEY_W-1:0] rdata
);

	logic signed [stsi_pkg::KEY_W-1:0] mem_q [stsi_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end

endmodule

@@ hw/rtl/stsi_cmp.sv @@
// Shared signed key comparator used by every search probe.
module stsi_cmp (
	input  logic signed [stsi_pkg::KEY_W-1:0] a,
	input  logic signed [stsi_pkg::KEY_W-1:0] b,
	output stsi_pkg::cmp_res_t                res
);

	assign res.eq = (a == b);
	assign res.lt = (a < b);

endmodule

@@ hw/rtl/stsi_ctrl.sv @@
// Sequencer: append, binary search probes, swap and insert shift over the key table.
module stsi_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               kind,
	input  logic signed [stsi_pkg::KEY_W-1:0]  key,
	input  logic                               take,
	input  logic signed [stsi_pkg::KEY_W-1:0]  rdata,
	output logic                               idle,
	output stsi_pkg::mem_req_t                 mem,
	output stsi_pkg::res_t                     res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_SW1   = 3'd3;
	localparam logic [2:0] S_SW2   = 3'd4;
	localparam logic [2:0] S_SHIFT = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	localparam int AW = stsi_pkg::AW;
	localparam int CW = stsi_pkg::CW;

	logic [2:0]                         state_q;
	logic signed [stsi_pkg::KEY_W-1:0]  key_q;
	logic [CW-1:0]                      low_q;
	logic [CW-1:0]                      hp1_q;
	logic [AW-1:0]                      mid_q;
	logic [CW-1:0]                      p_q;
	logic [AW-1:0]                      dst_q;
	logic                               pend_q;
	logic [CW-1:0]                      fill_q;
	logic [stsi_pkg::ST_W-1:0]          st_q;
	logic [AW-1:0]                      pos_q;

	logic [CW:0]         mid_sum;
	logic [AW-1:0]       mid_w;
	logic                full;
	logic                is_last;
	logic                shift_more;
	stsi_pkg::cmp_res_t  cmp;

	stsi_cmp u_cmp (
		.a   (rdata),
		.b   (key_q),
		.res (cmp)
	);

	assign mid_sum    = {1'b0, low_q} + {1'b0, hp1_q} - (CW+1)'(1);
	assign mid_w      = AW'(mid_sum >> 1);
	assign full       = (fill_q == CW'(stsi_pkg::TABLE_DEPTH));
	assign is_last    = ((CW'(mid_q) + CW'(1)) == fill_q);
	assign shift_more = (p_q > low_q);

	assign idle       = (state_q == S_IDLE);
	assign res.done   = (state_q == S_DONE);
	assign res.status = st_q;
	assign res.pos    = pos_q;
	assign res.fill   = fill_q;

	always_comb begin
		mem = '0;
		case (state_q)
			S_IDLE: begin
				if (start && kind == stsi_pkg::KIND_APPEND && !full) begin
					mem.we    = 1'b1;
					mem.waddr = AW'(fill_q);
					mem.wdata = key;
				end
			end
			S_SRCH: begin
				if (low_q < hp1_q) begin
					mem.re    = 1'b1;
					mem.raddr = mid_w;
				end
			end
			S_CMP: begin
				if (cmp.eq && !is_last) begin
					mem.re    = 1'b1;
					mem.raddr = mid_q + AW'(1);
				end
			end
			S_SW1: begin
				mem.we    = 1'b1;
				mem.waddr = mid_q;
				mem.wdata = rdata;
			end
			S_SW2: begin
				mem.we    = 1'b1;
				mem.waddr = mid_q + AW'(1);
				mem.wdata = key_q;
			end
			S_SHIFT: begin
				if (shift_more) begin
					mem.re    = 1'b1;
					mem.raddr = AW'(p_q - CW'(1));
				end
				if (pend_q) begin
					mem.we    = 1'b1;
					mem.waddr = dst_q;
					mem.wdata = rdata;
				end else if (!shift_more) begin
					mem.we    = 1'b1;
					mem.waddr = AW'(low_q);
					mem.wdata = key_q;
				end
			end
			default: begin
				mem = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			pend_q  <= 1'b0;
			key_q   <= '0;
			low_q   <= '0;
			hp1_q   <= '0;
			mid_q   <= '0;
			p_q     <= '0;
			dst_q   <= '0;
			st_q    <= '0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q <= key;
						low_q <= '0;
						hp1_q <= fill_q;
						if (kind == stsi_pkg::KIND_APPEND) begin
							state_q <= S_DONE;
							if (full) begin
								st_q  <= stsi_pkg::ST_FULL;
								pos_q <= '0;
							end else begin
								st_q   <= stsi_pkg::ST_APPENDED;
								pos_q  <= AW'(fill_q);
								fill_q <= fill_q + CW'(1);
							end
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (low_q < hp1_q) begin
						mid_q   <= mid_w;
						state_q <= S_CMP;
					end else if (full) begin
						st_q    <= stsi_pkg::ST_FULL;
						pos_q   <= '0;
						state_q <= S_DONE;
					end else begin
						p_q     <= fill_q;
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_CMP: begin
					pos_q <= mid_q;
					if (cmp.eq) begin
						if (is_last) begin
							st_q    <= stsi_pkg::ST_AT_LAST;
							state_q <= S_DONE;
						end else begin
							st_q    <= stsi_pkg::ST_SWAPPED;
							state_q <= S_SW1;
						end
					end else begin
						if (cmp.lt) begin
							low_q <= CW'(mid_q) + CW'(1);
						end else begin
							hp1_q <= CW'(mid_q);
						end
						state_q <= S_SRCH;
					end
				end
				S_SW1: begin
					state_q <= S_SW2;
				end
				S_SW2: begin
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					if (shift_more) begin
						dst_q  <= AW'(p_q);
						p_q    <= p_q - CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							st_q    <= stsi_pkg::ST_INSERTED;
							pos_q   <= AW'(low_q);
							fill_q  <= fill_q + CW'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/sorted_table_search_swap_insert.sv @@
// Sorted key table with binary search, swap on hit and ordered insert (top level).
//
// Holds up to 64 signed 32-bit keys in one single-port-read, single-port-write
// memory plus a fill count cleared by reset. An append writes the key after
// the last entry. A search runs binary-search probes (memory read, then
// compare in the shared comparator), at most 7 probes; a hit swaps the key
// with the next entry unless it is the last, a miss shifts the larger entries
// up one per cycle through the memory ports and inserts the key, or reports
// full if the table is full. One item is processed at a time; the result sits
// in an output register, so a new item is taken once the sequencer is idle even
// if the previous result has not yet been transferred.
module sorted_table_search_swap_insert (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic signed [stsi_pkg::KEY_W-1:0]   key,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [stsi_pkg::ST_W-1:0]           status,
	output logic [stsi_pkg::POS_W-1:0]          position,
	output logic [stsi_pkg::ENT_W-1:0]          entries
);

	logic                               idle;
	logic                               take;
	logic signed [stsi_pkg::KEY_W-1:0]  rdata;
	stsi_pkg::mem_req_t                 mem;
	stsi_pkg::res_t                     res;

	assign in_ready = idle;
	assign take     = res.done && (!out_valid || out_ready);

	stsi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid && idle),
		.kind   (kind),
		.key    (key),
		.take   (take),
		.rdata  (rdata),
		.idle   (idle),
		.mem    (mem),
		.res    (res)
	);

	stsi_ram u_ram (
		.clk   (clk),
		.req   (mem),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status   <= res.status;
			position <= stsi_pkg::POS_W'(res.pos);
			entries  <= stsi_pkg::ENT_W'(res.fill);
		end
	end

endmodule

@@ hw/rtl/stsi_checker.sv @@
// Port-level checker for the sorted key table, bound to the top level.
module stsi_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [stsi_pkg::ST_W-1:0]  status,
	input logic [stsi_pkg::POS_W-1:0] position,
	input logic [stsi_pkg::ENT_W-1:0] entries
);

	a_entries_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries <= stsi_pkg::ENT_W'(stsi_pkg::TABLE_DEPTH))
		else $error("entries beyond table depth");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == stsi_pkg::ST_FULL |->
		position == '0 && entries == stsi_pkg::ENT_W'(stsi_pkg::TABLE_DEPTH))
		else $error("full result with bad position or count");

	a_append_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == stsi_pkg::ST_APPENDED |->
		stsi_pkg::ENT_W'(position) + stsi_pkg::ENT_W'(1) == entries)
		else $error("append position is not the last entry");

	a_pos_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != stsi_pkg::ST_FULL |->
		stsi_pkg::ENT_W'(position) < entries)
		else $error("position outside valid entries");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
		&& $stable(entries))
		else $error("stalled result changed");

endmodule

bind sorted_table_search_swap_insert stsi_checker u_stsi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.position  (position),
	.entries   (entries)
);
